/* rtl/etrd_pkg.sv */
`default_nettype none
package etrd_pkg;

   localparam int SLOT_BITS  = 4;
   localparam int BYTE_BITS  = 8;
   localparam int COUNT_BITS = 16;
   localparam int CSR_BITS   = 64;
   localparam int DECL_BITS  = 24;

   localparam logic [1:0] CSR_SLOTS_LOW  = 2'd0;
   localparam logic [1:0] CSR_SLOTS_HIGH = 2'd1;
   localparam logic [1:0] CSR_ESC_COUNT  = 2'd2;
   localparam logic [1:0] CSR_DECL_LEN   = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_TRUNC    = 2'd2;
   localparam logic [1:0] STATUS_MISMATCH = 2'd3;

   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] slot;
   } match_type;

   typedef struct packed {
      logic                  emit;
      logic                  run_valid;
      logic [BYTE_BITS-1:0]  run_value;
      logic [COUNT_BITS-1:0] run_count;
      logic                  finished;
      logic [1:0]            status;
   } result_type;

endpackage
`default_nettype wire

/* rtl/etrd_match.sv */
`default_nettype none
module etrd_match #(
   parameter int MAX_ESCAPES = 16
) (
   input  wire logic [7:0]                    body_byte,
   input  wire logic [MAX_ESCAPES-1:0][7:0]   escape_slots,
   input  wire logic [4:0]                    escape_count,
   output etrd_pkg::match_type                match
);
   import etrd_pkg::*;

   always_comb begin
      match = '0;
      for (int i = 0; i < MAX_ESCAPES; i++) begin
         if ((5'(i) < escape_count) && (escape_slots[i] == body_byte)) begin
            match.hit  = 1'b1;
            match.slot = SLOT_BITS'(i);
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/etrd_core.sv */
`default_nettype none
module etrd_core #(
   parameter int LENGTH_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             body_byte,
   input  wire logic                   is_last,
   input  etrd_pkg::match_type         match,
   input  wire logic [LENGTH_BITS-1:0] declared_length,
   output etrd_pkg::result_type        result
);
   import etrd_pkg::*;

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_CNT8     = 3'd1;
   localparam logic [2:0] PH_CNT16_LO = 3'd2;
   localparam logic [2:0] PH_CNT16_HI = 3'd3;
   localparam logic [2:0] PH_VALUE    = 3'd4;
   localparam logic [2:0] PH_HALT     = 3'd5;

   localparam int SUM_W = ((LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS) + 1;

   localparam logic [SLOT_BITS-1:0] SLOT_CNT8  = SLOT_BITS'(0);
   localparam logic [SLOT_BITS-1:0] SLOT_CNT16 = SLOT_BITS'(2);

   logic [2:0]             phase_ff, phase_in;
   logic [7:0]             low_byte_ff, low_byte_in;
   logic [COUNT_BITS-1:0]  pending_ff, pending_in;
   logic [LENGTH_BITS-1:0] produced_ff, produced_in;
   logic [1:0]             error_ff, error_in;

   logic [SUM_W-1:0] run_end;
   logic             overflow;

   assign run_end  = SUM_W'(produced_ff) + SUM_W'(pending_ff);
   assign overflow = (produced_ff >= declared_length) ? (pending_ff != '0)
                                                      : (run_end > SUM_W'(declared_length));

   always_comb begin
      phase_in    = phase_ff;
      low_byte_in = low_byte_ff;
      pending_in  = pending_ff;
      produced_in = produced_ff;
      error_in    = error_ff;
      result      = '0;

      case (phase_ff)
         PH_IDLE: begin
            if (produced_ff < declared_length) begin
               if (!match.hit) begin
                  result.run_valid = 1'b1;
                  result.run_value = body_byte;
                  result.run_count = COUNT_BITS'(1);
                  produced_in      = produced_ff + LENGTH_BITS'(1);
               end else if (match.slot == SLOT_CNT8) begin
                  phase_in = PH_CNT8;
               end else if (match.slot == SLOT_CNT16) begin
                  phase_in = PH_CNT16_LO;
               end else begin
                  pending_in = COUNT_BITS'(match.slot);
                  phase_in   = PH_VALUE;
               end
            end
         end
         PH_CNT8: begin
            pending_in = COUNT_BITS'(body_byte);
            phase_in   = PH_VALUE;
         end
         PH_CNT16_LO: begin
            low_byte_in = body_byte;
            phase_in    = PH_CNT16_HI;
         end
         PH_CNT16_HI: begin
            pending_in = {body_byte, low_byte_ff};
            phase_in   = PH_VALUE;
         end
         PH_VALUE: begin
            phase_in = PH_IDLE;
            if (overflow) begin
               error_in    = STATUS_OVERFLOW;
               phase_in    = PH_HALT;
               result.emit = 1'b1;
            end else if (pending_ff != '0) begin
               result.run_valid = 1'b1;
               result.run_value = body_byte;
               result.run_count = pending_ff;
               produced_in      = LENGTH_BITS'(run_end);
            end
         end
         default: begin
         end
      endcase

      if (result.run_valid) begin
         result.emit = 1'b1;
      end

      if (is_last) begin
         if (error_in == STATUS_OK) begin
            if (phase_in != PH_IDLE) begin
               error_in = STATUS_TRUNC;
            end else if (produced_in != declared_length) begin
               error_in = STATUS_MISMATCH;
            end
         end
         result.emit     = 1'b1;
         result.finished = 1'b1;
      end

      result.status = error_in;

      if (is_last) begin
         phase_in    = PH_IDLE;
         low_byte_in = '0;
         pending_in  = '0;
         produced_in = '0;
         error_in    = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         low_byte_ff <= '0;
         pending_ff  <= '0;
         produced_ff <= '0;
         error_ff    <= STATUS_OK;
      end else if (step) begin
         phase_ff    <= phase_in;
         low_byte_ff <= low_byte_in;
         pending_ff  <= pending_in;
         produced_ff <= produced_in;
         error_ff    <= error_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/escape_table_rle_decoder_unit.sv */
// Escape-table run-length decoder, single-byte pass.
// req_*: one body byte per transfer, req_tlast marks the last byte of a body.
// rsp_*: zero or one result per byte: a (value, count) run, an error report,
//   and always a tlast result for the last byte carrying the body status.
// csr_*: write-only registers (escape slots low/high, escape count, declared
//   length); user writes them only while no byte is in flight (not enforced).
// Timing: a byte is registered at the input at its transfer, decoded against
//   the escape table and the body state from the input register, and its
//   result, if any, is registered in the output register that drives
//   rsp_tvalid when the byte advances.
// Throughput: one byte per cycle while the output is not stalled; the escape
//   table is a parallel compare, and the body state updates with the decode.
// Stall: while rsp_tvalid is held by a low rsp_tready, decode stops; one more
//   byte is held in the input register, after which req_tready drops.
//   Bytes that give no result never occupy the output register.
// Reset: registers return to slots 0, escape count 1, declared length 0; the
//   body state returns to expecting a literal or an escape.
`default_nettype none
module escape_table_rle_decoder_unit #(
   parameter int MAX_ESCAPES = 16,
   parameter int LENGTH_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // body_byte
   input  wire logic        req_tlast,   // is_last
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,   // run_value[7:0], run_count[23:8]
   output      logic [2:0]  rsp_tuser,   // run_valid[0], status[2:1]
   output      logic        rsp_tlast,   // finished
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   import etrd_pkg::*;

   localparam int LOW_SLOTS = (MAX_ESCAPES < 8) ? MAX_ESCAPES : 8;
   localparam int DECL_W    = (LENGTH_BITS < DECL_BITS) ? LENGTH_BITS : DECL_BITS;

   logic [MAX_ESCAPES-1:0][7:0] slots_ff;
   logic [4:0]                  esc_count_ff;
   logic [LENGTH_BITS-1:0]      decl_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;

   match_type  match;
   result_type result;

   logic        out_valid_ff;
   logic [23:0] out_data_ff;
   logic [2:0]  out_user_ff;
   logic        out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff     <= '0;
         esc_count_ff <= 5'd1;
         decl_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLOTS_LOW: begin
               for (int i = 0; i < LOW_SLOTS; i++) begin
                  slots_ff[i] <= csr_wdata[i*8 +: 8];
               end
            end
            CSR_SLOTS_HIGH: begin
               for (int i = 8; i < MAX_ESCAPES; i++) begin
                  slots_ff[i] <= csr_wdata[(i-8)*8 +: 8];
               end
            end
            CSR_ESC_COUNT: esc_count_ff <= csr_wdata[4:0];
            CSR_DECL_LEN:  decl_ff      <= LENGTH_BITS'(csr_wdata[DECL_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   etrd_match #(
      .MAX_ESCAPES (MAX_ESCAPES)
   ) u_match (
      .body_byte    (in_byte_ff),
      .escape_slots (slots_ff),
      .escape_count (esc_count_ff),
      .match        (match)
   );

   etrd_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .body_byte       (in_byte_ff),
      .is_last         (in_last_ff),
      .match           (match),
      .declared_length (decl_ff),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= result.emit;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.emit) begin
         out_data_ff <= {result.run_count, result.run_value};
         out_user_ff <= {result.status, result.run_valid};
         out_last_ff <= result.finished;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[23:8] != 16'd0)
      else $error("run result with zero count");

   a_error_no_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:1] == STATUS_OVERFLOW || rsp_tuser[2:1] == STATUS_TRUNC)
      |-> !rsp_tuser[0])
      else $error("run reported together with overflow or truncation");

   a_midbody_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser[2:1] == STATUS_OK
                                  || rsp_tuser[2:1] == STATUS_OVERFLOW)
      else $error("end-of-body status before the last byte");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("held input byte lost or changed");

endmodule
`default_nettype wire
